>>> hdl/kf400_pkg.sv
// ----------------------------------------------------------------------------
// Keccak-f[400] round package
// Request types, round constants and the rho and pi tables that are shared by
// the round pipeline.
// ----------------------------------------------------------------------------
package kf400_pkg;

	localparam int unsigned LANE_W = 16;
	localparam int unsigned NUM_LANES = 25;
	localparam int unsigned NUM_COLS = 5;
	localparam int unsigned NUM_ROUNDS = 20;
	localparam int unsigned STATE_W = LANE_W * NUM_LANES;

	typedef logic [LANE_W-1:0] lane_t;
	typedef logic [4:0] round_idx_t;

	typedef struct packed {
		logic [63:0] lanes_0_to_3;
		logic [63:0] lanes_4_to_7;
		logic [63:0] lanes_8_to_11;
		logic [63:0] lanes_12_to_15;
		logic [63:0] lanes_16_to_19;
		logic [63:0] lanes_20_to_23;
		logic [15:0] lane_24;
		round_idx_t  round_index;
	} in_req_t;

	typedef struct packed {
		logic [63:0] out_lanes_0_to_3;
		logic [63:0] out_lanes_4_to_7;
		logic [63:0] out_lanes_8_to_11;
		logic [63:0] out_lanes_12_to_15;
		logic [63:0] out_lanes_16_to_19;
		logic [63:0] out_lanes_20_to_23;
		logic [15:0] out_lane_24;
	} out_req_t;

	localparam lane_t ROUND_CONST [NUM_ROUNDS] = '{
		16'h0001, 16'h8082, 16'h808A, 16'h8000, 16'h808B, 16'h0001, 16'h8081,
		16'h8009, 16'h008A, 16'h0088, 16'h8009, 16'h000A, 16'h808B, 16'h008B,
		16'h8089, 16'h8003, 16'h8002, 16'h0080, 16'h800A, 16'h000A
	};

	// Source lane of each permuted position, and its rotation.
	localparam int unsigned PI_SRC [NUM_LANES] = '{
		0, 15, 5, 20, 10, 6, 21, 11, 1, 16, 12, 2, 17, 7, 22,
		18, 8, 23, 13, 3, 24, 14, 4, 19, 9
	};
	localparam int unsigned RHO_ROT [NUM_LANES] = '{
		0, 12, 1, 11, 14, 12, 4, 6, 4, 7, 11, 3, 9, 10, 7,
		5, 13, 8, 15, 9, 14, 13, 2, 8, 2
	};

	function automatic lane_t rotl16(lane_t v, int unsigned n);
		logic [2*LANE_W-1:0] w;
		w = {v, v} << (n % LANE_W);
		return w[2*LANE_W-1:LANE_W];
	endfunction

	function automatic lane_t round_const(round_idx_t idx);
		lane_t rc;
		rc = '0;
		if (idx < round_idx_t'(NUM_ROUNDS)) begin
			rc = ROUND_CONST[idx];
		end
		return rc;
	endfunction

endpackage

>>> hdl/keccak_f400_round.sv
// ----------------------------------------------------------------------------
// Keccak-f[400] round
// One full round (theta, rho, pi, chi, iota) over a 400-bit state, in a
// three-stage pipeline.
// ----------------------------------------------------------------------------
// Usage:
// A request on the src channel carries the whole state as 25 lanes of 16 bits
// plus the round index; it is taken at an edge where src_valid is high and
// src_stall is low. The new state leaves on the dst channel under the same
// valid and stall rule. Round indexes 20 to 31 give a zero round constant.
// dst_valid rises once a request has reached the last register stage, and
// one request enters every cycle while src_stall is low; the three register
// stages are the column parity, the theta, rho and pi mix, and chi with iota.
// While dst_stall is high the output register holds its result; the stages
// in front of it keep filling any empty slot, and src_stall rises only when
// all three stages hold a request. Nothing is dropped or repeated.
// Reset empties the pipeline; the block keeps no state between requests.
// ----------------------------------------------------------------------------
module keccak_f400_round (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	output logic               src_stall,
	input  kf400_pkg::in_req_t  src_req,
	output logic               dst_valid,
	input  logic               dst_stall,
	output kf400_pkg::out_req_t dst_req
);
	import kf400_pkg::*;

	logic [STATE_W-1:0] in_flat;
	lane_t              a_in [NUM_LANES];
	lane_t              col_in [NUM_COLS];

	lane_t              a_s1 [NUM_LANES];
	lane_t              col_s1 [NUM_COLS];
	lane_t              rc_s1;
	logic               v_s1;

	lane_t              d_c [NUM_COLS];
	lane_t              b_c [NUM_LANES];

	lane_t              b_s2 [NUM_LANES];
	lane_t              rc_s2;
	logic               v_s2;

	lane_t              chi_c [NUM_LANES];
	logic [STATE_W-1:0] out_flat_c;
	logic [STATE_W-1:0] out_s3;
	logic               v_s3;

	logic               ready_s1;
	logic               ready_s2;
	logic               ready_s3;

	assign ready_s3 = !v_s3 || !dst_stall;
	assign ready_s2 = !v_s2 || ready_s3;
	assign ready_s1 = !v_s1 || ready_s2;
	assign src_stall = !ready_s1;

	assign in_flat = {src_req.lane_24, src_req.lanes_20_to_23, src_req.lanes_16_to_19,
		src_req.lanes_12_to_15, src_req.lanes_8_to_11, src_req.lanes_4_to_7,
		src_req.lanes_0_to_3};

	always_comb begin
		for (int k = 0; k < NUM_LANES; k++) begin
			a_in[k] = in_flat[LANE_W*k +: LANE_W];
		end
		for (int x = 0; x < NUM_COLS; x++) begin
			col_in[x] = a_in[5*x] ^ a_in[5*x+1] ^ a_in[5*x+2] ^ a_in[5*x+3] ^ a_in[5*x+4];
		end
	end

	always_comb begin
		for (int x = 0; x < NUM_COLS; x++) begin
			d_c[x] = col_s1[(x+4)%5] ^ rotl16(col_s1[(x+1)%5], 1);
		end
		for (int k = 0; k < NUM_LANES; k++) begin
			b_c[k] = rotl16(a_s1[PI_SRC[k]] ^ d_c[PI_SRC[k]/5], RHO_ROT[k]);
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_LANES; k++) begin
			chi_c[k] = b_s2[k] ^ (~b_s2[(k+5)%25] & b_s2[(k+10)%25]);
		end
		chi_c[0] = chi_c[0] ^ rc_s2;
		for (int k = 0; k < NUM_LANES; k++) begin
			out_flat_c[LANE_W*k +: LANE_W] = chi_c[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				v_s1 <= src_valid;
			end
			if (ready_s2) begin
				v_s2 <= v_s1;
			end
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && src_valid) begin
			a_s1   <= a_in;
			col_s1 <= col_in;
			rc_s1  <= round_const(src_req.round_index);
		end
		if (ready_s2 && v_s1) begin
			b_s2  <= b_c;
			rc_s2 <= rc_s1;
		end
		if (ready_s3 && v_s2) begin
			out_s3 <= out_flat_c;
		end
	end

	assign dst_valid = v_s3;
	assign dst_req.out_lanes_0_to_3   = out_s3[63:0];
	assign dst_req.out_lanes_4_to_7   = out_s3[127:64];
	assign dst_req.out_lanes_8_to_11  = out_s3[191:128];
	assign dst_req.out_lanes_12_to_15 = out_s3[255:192];
	assign dst_req.out_lanes_16_to_19 = out_s3[319:256];
	assign dst_req.out_lanes_20_to_23 = out_s3[383:320];
	assign dst_req.out_lane_24        = out_s3[399:384];

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		src_stall |-> (v_s1 && v_s2 && v_s3 && dst_stall))
		else $error("input stalled while the pipeline has a free slot");

	a_s1_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && ready_s2) |=> v_s2)
		else $error("request lost between stage one and stage two");

	a_s2_moves_on: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && ready_s3) |=> v_s3)
		else $error("request lost between stage two and the output");

	a_held_output: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && dst_stall) |=> (v_s3 && $stable(out_s3)))
		else $error("stalled result changed or vanished");
`endif

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// Keccak-f[400] round testbench
// Drives full 400-bit states with round indexes into the round block and
// checks every new state against an in-bench model of theta, rho, pi, chi
// and iota, under random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import kf400_pkg::*;

	typedef enum logic [1:0] {PH_SRC_LIGHT, PH_SRC_HEAVY, PH_NO_IDLE} idle_phase_t;

	localparam int unsigned HOLD_CYCLES = 60;
	localparam int unsigned MAX_REPORTS = 10;
	localparam int unsigned RANDOM_ITEMS = 2000;

	localparam lane_t IOTA_RC [20] = '{
		16'h0001, 16'h8082, 16'h808A, 16'h8000, 16'h808B, 16'h0001, 16'h8081,
		16'h8009, 16'h008A, 16'h0088, 16'h8009, 16'h000A, 16'h808B, 16'h008B,
		16'h8089, 16'h8003, 16'h8002, 16'h0080, 16'h800A, 16'h000A
	};
	localparam int unsigned LANE_SRC [25] = '{
		0, 15, 5, 20, 10, 6, 21, 11, 1, 16, 12, 2, 17, 7, 22,
		18, 8, 23, 13, 3, 24, 14, 4, 19, 9
	};
	localparam int unsigned LANE_ROT [25] = '{
		0, 12, 1, 11, 14, 12, 4, 6, 4, 7, 11, 3, 9, 10, 7,
		5, 13, 8, 15, 9, 14, 13, 2, 8, 2
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic src_valid = 1'b0;
	logic src_stall;
	in_req_t src_req = '0;
	logic dst_valid;
	logic dst_stall = 1'b0;
	out_req_t dst_req;

	in_req_t pending_states[$];
	out_req_t next_states[$];
	out_req_t expected_state;
	int unsigned total_states = 0;
	int unsigned accepted_states = 0;
	int unsigned mismatches = 0;
	int unsigned hold_count = 0;
	logic hold_done = 1'b0;
	logic field_bad;
	idle_phase_t phase;
	int unsigned src_idle_pct;
	int unsigned dst_idle_pct;

	keccak_f400_round dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_req   (src_req),
		.dst_valid (dst_valid),
		.dst_stall (dst_stall),
		.dst_req   (dst_req)
	);

	assign phase = (accepted_states < total_states / 3) ? PH_SRC_LIGHT :
		(accepted_states < 2 * total_states / 3) ? PH_SRC_HEAVY : PH_NO_IDLE;
	assign src_idle_pct = (phase == PH_SRC_LIGHT) ? 21 : (phase == PH_SRC_HEAVY) ? 77 : 0;
	assign dst_idle_pct = (phase == PH_SRC_LIGHT) ? 77 : (phase == PH_SRC_HEAVY) ? 21 : 0;

	function automatic lane_t rotate_lane(lane_t v, int unsigned n);
		if (n == 0) begin
			return v;
		end
		return (v << n) | (v >> (LANE_W - n));
	endfunction

	function automatic out_req_t keccak_round(in_req_t r);
		logic [383:0] packed_in;
		logic [383:0] packed_out;
		lane_t a [25];
		lane_t b [25];
		lane_t col [5];
		lane_t d [5];
		out_req_t o;
		packed_in = {r.lanes_20_to_23, r.lanes_16_to_19, r.lanes_12_to_15,
			r.lanes_8_to_11, r.lanes_4_to_7, r.lanes_0_to_3};
		for (int k = 0; k < 24; k++) begin
			a[k] = packed_in[16*k +: 16];
		end
		a[24] = r.lane_24;
		for (int x = 0; x < 5; x++) begin
			col[x] = a[5*x] ^ a[5*x+1] ^ a[5*x+2] ^ a[5*x+3] ^ a[5*x+4];
		end
		for (int x = 0; x < 5; x++) begin
			d[x] = col[(x+4)%5] ^ rotate_lane(col[(x+1)%5], 1);
		end
		for (int k = 0; k < 25; k++) begin
			b[k] = rotate_lane(a[LANE_SRC[k]] ^ d[LANE_SRC[k]/5], LANE_ROT[k]);
		end
		for (int k = 0; k < 25; k++) begin
			a[k] = b[k] ^ (~b[(k+5)%25] & b[(k+10)%25]);
		end
		if (r.round_index < NUM_ROUNDS) begin
			a[0] = a[0] ^ IOTA_RC[r.round_index];
		end
		for (int k = 0; k < 24; k++) begin
			packed_out[16*k +: 16] = a[k];
		end
		{o.out_lanes_20_to_23, o.out_lanes_16_to_19, o.out_lanes_12_to_15,
			o.out_lanes_8_to_11, o.out_lanes_4_to_7, o.out_lanes_0_to_3} = packed_out;
		o.out_lane_24 = a[24];
		return o;
	endfunction

	function automatic in_req_t make_state(logic [383:0] lanes, lane_t last, round_idx_t idx);
		in_req_t r;
		{r.lanes_20_to_23, r.lanes_16_to_19, r.lanes_12_to_15,
			r.lanes_8_to_11, r.lanes_4_to_7, r.lanes_0_to_3} = lanes;
		r.lane_24 = last;
		r.round_index = idx;
		return r;
	endfunction

	function automatic lane_t random_lane();
		unique case ($urandom_range(0, 7))
			0: begin
				return '0;
			end
			1: begin
				return '1;
			end
			2: begin
				return lane_t'(1) << $urandom_range(0, LANE_W - 1);
			end
			default: begin
				return lane_t'($urandom);
			end
		endcase
	endfunction

	function automatic in_req_t random_state();
		logic [383:0] lanes;
		round_idx_t idx;
		for (int k = 0; k < 24; k++) begin
			lanes[16*k +: 16] = random_lane();
		end
		if ($urandom_range(0, 7) == 0) begin
			idx = round_idx_t'($urandom_range(NUM_ROUNDS, 31));
		end else begin
			idx = round_idx_t'($urandom_range(0, NUM_ROUNDS - 1));
		end
		return make_state(lanes, random_lane(), idx);
	endfunction

	initial begin
		forever begin
			#4 clk = ~clk;
		end
	end

	initial begin
		#2ms;
		$display("FAILED: results differ");
		$finish;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_valid <= 1'b0;
		end else begin
			if (src_valid && !src_stall) begin
				next_states.push_back(keccak_round(src_req));
				accepted_states <= accepted_states + 1;
			end
			if (!src_valid || !src_stall) begin
				if (pending_states.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					src_valid <= 1'b1;
					src_req <= pending_states.pop_front();
				end else begin
					src_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_stall <= 1'b0;
			hold_count <= 0;
			hold_done <= 1'b0;
		end else begin
			if (hold_count > 0) begin
				dst_stall <= 1'b1;
				hold_count <= hold_count - 1;
			end else if (!hold_done && phase == PH_NO_IDLE) begin
				dst_stall <= 1'b1;
				hold_count <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				dst_stall <= ($urandom_range(0, 99) < dst_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			if (next_states.size() == 0) begin
				mismatches <= mismatches + 1;
				if (mismatches < MAX_REPORTS) begin
					$display("unexpected request on output: %h", dst_req);
				end
			end else begin
				expected_state = next_states.pop_front();
				field_bad = (dst_req.out_lanes_0_to_3 !== expected_state.out_lanes_0_to_3) ||
					(dst_req.out_lanes_4_to_7 !== expected_state.out_lanes_4_to_7) ||
					(dst_req.out_lanes_8_to_11 !== expected_state.out_lanes_8_to_11) ||
					(dst_req.out_lanes_12_to_15 !== expected_state.out_lanes_12_to_15) ||
					(dst_req.out_lanes_16_to_19 !== expected_state.out_lanes_16_to_19) ||
					(dst_req.out_lanes_20_to_23 !== expected_state.out_lanes_20_to_23) ||
					(dst_req.out_lane_24 !== expected_state.out_lane_24);
				if (field_bad) begin
					mismatches <= mismatches + 1;
					if (mismatches < MAX_REPORTS) begin
						$display("state mismatch: expected %h actual %h",
							expected_state, dst_req);
					end
				end
			end
		end
	end

	initial begin
		logic [383:0] lanes;
		for (int r = 0; r < NUM_ROUNDS; r++) begin
			unique case (r % 4)
				0: begin
					lanes = '0;
				end
				1: begin
					lanes = '1;
				end
				2: begin
					lanes = {48{8'hA5}};
				end
				default: begin
					lanes = 384'd1 << (r * 17);
				end
			endcase
			pending_states.push_back(make_state(lanes, lanes[15:0], round_idx_t'(r)));
		end
		pending_states.push_back(make_state('0, '0, round_idx_t'(NUM_ROUNDS)));
		pending_states.push_back(make_state('1, '1, '1));
		pending_states.push_back(make_state({48{8'h55}}, 16'hAAAA, round_idx_t'(NUM_ROUNDS)));
		pending_states.push_back(make_state('0, 16'h8000, '1));
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			pending_states.push_back(random_state());
		end
		total_states = pending_states.size();

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_states < total_states) begin
			@(posedge clk);
		end
		while (next_states.size() > 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0 && next_states.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
